[hw/rtl/arc4_pkg.sv]
package arc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = $clog2(SBOX_DEPTH);

    // Load address map
    localparam logic [8:0] ADDR_IDX_I = 9'd256;
    localparam logic [8:0] ADDR_IDX_J = 9'd257;

    // Command codes carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_GEN  = 1'b1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

endpackage

[hw/rtl/arc4_keystream_generator_top.sv]
// Load transaction: no result; ready again on the next cycle.
// Generate transaction: from accept through S_RD_J, S_SWAP1 and S_SWAP2 (and S_DONE while the
//   output register is full) to the result; it takes three dependent reads and two writes on the S-box RAM.
// Throughput: one load every cycle while idle; no new command is accepted until a generate has finished.
// Reset (i_rst_n low, synchronous) clears i, j and the handshake state;
//   the S-box holds no reset value and must be loaded before use.
module arc4_keystream_generator_top
    import arc4_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [8:0] load_addr, [16:9] load_value, [23:17] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] cmd
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] key_byte
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_J,
        S_SWAP1,
        S_SWAP2,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [SBOX_AW-1:0]   r_i, n_i;
    logic [SBOX_AW-1:0]   r_j, n_j;
    logic [7:0]           r_a, n_a;
    logic [7:0]           r_b, n_b;
    logic [7:0]           r_key, n_key;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_data, n_out_data;

    logic [7:0]           r_sbox [SBOX_DEPTH];
    logic [7:0]           r_rdata;

    logic                 s_accept;
    logic [8:0]           load_addr;
    logic [7:0]           load_value;
    logic                 out_free;
    logic [SBOX_AW-1:0]   rd_addr;
    logic                 we;
    logic [SBOX_AW-1:0]   wr_addr;
    logic [7:0]           wr_data;
    logic [SBOX_AW-1:0]   sum_addr;
    logic [7:0]           key_fwd;

    assign load_addr  = i_s_axis_tdata[8:0];
    assign load_value = i_s_axis_tdata[16:9];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Output index of the step; the RAM was read there before the swap landed
    assign sum_addr = r_a + r_b;

    // Patch in the swapped values; S[j] is written last so it wins when i == j
    always_comb begin
        if (sum_addr == r_j) begin
            key_fwd = r_a;
        end else if (sum_addr == r_i) begin
            key_fwd = r_b;
        end else begin
            key_fwd = r_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_b         = r_b;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        rd_addr     = r_i + 1'b1;
        we          = 1'b0;
        wr_addr     = load_addr[SBOX_AW-1:0];
        wr_data     = load_value;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_axis_tuser == CMD_GEN) begin
                        // Advance i and fetch S[i]
                        n_i     = r_i + 1'b1;
                        n_state = S_RD_J;
                    end else if (load_addr[8] == 1'b0) begin
                        we = 1'b1;
                    end else if (load_addr == ADDR_IDX_I) begin
                        n_i = load_value;
                    end else if (load_addr == ADDR_IDX_J) begin
                        n_j = load_value;
                    end
                end
            end
            S_RD_J: begin
                n_a     = r_rdata;
                n_j     = r_j + r_rdata;
                rd_addr = r_j + r_rdata;
                n_state = S_SWAP1;
            end
            S_SWAP1: begin
                n_b     = r_rdata;
                we      = 1'b1;
                wr_addr = r_i;
                wr_data = r_rdata;
                rd_addr = r_a + r_rdata;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                we      = 1'b1;
                wr_addr = r_j;
                wr_data = r_a;
                n_key   = key_fwd;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = key_fwd;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the byte until the output register drains
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_key;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_key      <= n_key;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_sbox[wr_addr] <= wr_data;
        end
        r_rdata <= r_sbox[rd_addr];
    end

    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tuser == CMD_GEN) |=> !o_s_axis_tready)
        else $error("generate accepted but input still ready");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tuser == CMD_LOAD) |=> (r_state == S_IDLE))
        else $error("load did not finish in one cycle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            ($past(r_state) == S_SWAP2 || $past(r_state) == S_DONE))
        else $error("result appeared outside the generate sequence");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !out_free) |=> (r_state == S_DONE))
        else $error("pending key byte dropped");

endmodule
